### rtl/gke_pkg.sv
package gke_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DIST_W = 40;
    localparam int KERNEL_W = 17;
    localparam int BW_W = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam int FEATURE_LIMIT_DEFAULT = 64;

    localparam logic [BW_W-1:0] INV_BW_RESET = 16'd3277;
    localparam logic [DIST_W-1:0] ACC_MAX = {DIST_W{1'b1}};

    // register index, taken from paddr[2]
    localparam logic REG_INV_BANDWIDTH = 1'b0;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### rtl/gaussian_kernel_entry_unit.sv
// Throughput: one feature per cycle, except while a row end waits for queue room;
//   row results come from the back sequencer, which takes a new row distance only
//   when idle and shares one 32x32 multiplier across its 12 squarings; a kernel that
//   flushes to zero skips the series and the squarings.
// Reset: rst_n clears accumulator, feature count, queue, sequencer and output valid,
//   and sets inv_bandwidth to 3277.
module gaussian_kernel_entry_unit
    import gke_pkg::*;
#(
    parameter int FEATURE_LIMIT = FEATURE_LIMIT_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // feature transaction
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] new_value,
    input  logic signed [SAMPLE_W-1:0] basis_value,
    input  logic                       last_feature,
    // result transaction
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [KERNEL_W-1:0]        kernel_value,
    output logic [DIST_W-1:0]          distance_squared,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [CFG_ADDR_W-1:0]      paddr,
    input  logic [CFG_DATA_W-1:0]      pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [BW_W-1:0]   inv_bw_reg;
    logic              cfg_write;

    queue_status_t     q_status;
    logic              q_push;
    logic [DIST_W-1:0] q_push_data;
    logic              q_pop;
    logic [DIST_W-1:0] q_pop_data;

    // Register file: one register, inv_bandwidth, at byte address 0.
    // Writes to any other index are dropped; reads of them return zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_INV_BANDWIDTH) ?
                       {{(CFG_DATA_W - BW_W){1'b0}}, inv_bw_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_bw_reg <= INV_BW_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_INV_BANDWIDTH))
        begin
            inv_bw_reg <= pwdata[BW_W-1:0];
        end
    end

    // Front: square each feature difference, accumulate with saturation, and
    // push the row distance into the queue at the row end (or at the feature limit).
    gke_front #(
        .FEATURE_LIMIT (FEATURE_LIMIT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .new_value   (new_value),
        .basis_value (basis_value),
        .last_feature(last_feature),
        .q_status    (q_status),
        .push        (q_push),
        .push_data   (q_push_data)
    );

    // Two-entry queue of row distances: lets the front keep streaming features
    // while the back works through the exponential of the previous row.
    gke_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    // Back: t = d * inv_bandwidth in two partial products, a cubic series on
    // t/4096, twelve roundings of e*e, then rounding to Q1.16 into the
    // output register.
    gke_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .inv_bandwidth    (inv_bw_reg),
        .q_status         (q_status),
        .q_data           (q_pop_data),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kernel_value     (kernel_value),
        .distance_squared (distance_squared)
    );

endmodule

### rtl/gke_queue.sv
module gke_queue
    import gke_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [DIST_W-1:0]   push_data,
    input  logic                pop,
    output logic [DIST_W-1:0]   pop_data,
    output queue_status_t       status
);

    localparam int DEPTH = 2;

    logic [DIST_W-1:0] mem_reg [DEPTH];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'(DEPTH));
    assign status.empty = (count_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### rtl/gke_front.sv
module gke_front
    import gke_pkg::*;
#(
    parameter int FEATURE_LIMIT = FEATURE_LIMIT_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] new_value,
    input  logic signed [SAMPLE_W-1:0] basis_value,
    input  logic                       last_feature,
    input  queue_status_t              q_status,
    output logic                       push,
    output logic [DIST_W-1:0]          push_data
);

    localparam int CNT_W = (FEATURE_LIMIT > 1) ? $clog2(FEATURE_LIMIT) : 1;

    logic [CNT_W-1:0]            count_reg;
    logic                        sq_valid_reg;
    logic                        sq_last_reg;
    logic [2*SAMPLE_W-1:0]       sq_reg;
    logic [DIST_W-1:0]           acc_reg;

    logic signed [SAMPLE_W:0]    diff;
    logic [SAMPLE_W-1:0]         mag;
    logic [2*SAMPLE_W-1:0]       sq_next;
    logic                        last_next;
    logic [DIST_W:0]             sum_wide;
    logic [DIST_W-1:0]           sum_sat;
    logic                        blocked;
    logic                        accept;
    logic                        advance;

    assign diff = {new_value[SAMPLE_W-1], new_value} - {basis_value[SAMPLE_W-1], basis_value};
    // |diff| never exceeds 65535, so the low 16 bits hold it
    assign mag = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    assign sq_next = mag * mag;
    assign last_next = last_feature || (count_reg == CNT_W'(FEATURE_LIMIT - 1));

    assign sum_wide = {1'b0, acc_reg} + {{(DIST_W + 1 - 2*SAMPLE_W){1'b0}}, sq_reg};
    assign sum_sat  = sum_wide[DIST_W] ? ACC_MAX : sum_wide[DIST_W-1:0];

    // hold the square stage while a row end waits for queue room
    assign blocked  = sq_valid_reg && sq_last_reg && q_status.full;
    assign in_stall = blocked;
    assign accept   = in_valid && !blocked;
    assign advance  = sq_valid_reg && !blocked;

    assign push      = advance && sq_last_reg;
    assign push_data = sum_sat;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_reg      <= sq_next;
            sq_last_reg <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sq_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= last_next ? '0 : count_reg + CNT_W'(1);
            end
            if (!blocked)
            begin
                sq_valid_reg <= in_valid;
            end
            if (advance)
            begin
                acc_reg <= sq_last_reg ? '0 : sum_sat;
            end
        end
    end

endmodule

### rtl/gke_back.sv
module gke_back
    import gke_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [BW_W-1:0]      inv_bandwidth,
    input  queue_status_t        q_status,
    input  logic [DIST_W-1:0]    q_data,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KERNEL_W-1:0]  kernel_value,
    output logic [DIST_W-1:0]    distance_squared
);

    localparam int SQUARINGS = 12;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [61:0] Q30_HALF = 62'h2000_0000;
    localparam logic [30:0] KERNEL_HALF = 31'd8192;
    localparam logic [KERNEL_W-1:0] KERNEL_ONE = 17'h1_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ARG,
        ST_SQ_S,
        ST_CUBE,
        ST_POLY,
        ST_SQ_E,
        ST_ROUND,
        ST_FIN
    } state_t;

    state_t              state_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [63:0]         prod_reg;
    logic [39:0]         tlo_reg;
    logic [21:0]         s_reg;
    logic [13:0]         s2_reg;
    logic [30:0]         e_reg;
    logic [3:0]          sq_cnt_reg;
    logic                out_valid_reg;
    logic [KERNEL_W-1:0] kernel_reg;
    logic [DIST_W-1:0]   dist_out_reg;

    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         prod_next;
    logic [55:0]         t_arg;
    logic [5:0]          s3;
    logic [11:0]         s3_scaled;
    logic [30:0]         e_poly;
    logic [61:0]         e_rounded;
    logic [30:0]         kernel_sum;
    logic                out_load;

    function automatic logic [30:0] div6(input logic [5:0] x);
        logic [11:0] p;
        // x * 43 / 256 matches x / 6 for every 6-bit x
        p = {6'd0, x} * 12'd43;
        return {27'd0, p[11:8]};
    endfunction

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_LO:
            begin
                mul_a = {8'd0, dist_reg[23:0]};
                mul_b = {16'd0, inv_bandwidth};
            end
            ST_MUL_HI:
            begin
                mul_a = {16'd0, dist_reg[39:24]};
                mul_b = {16'd0, inv_bandwidth};
            end
            ST_SQ_S:
            begin
                mul_a = {10'd0, s_reg};
                mul_b = {10'd0, s_reg};
            end
            ST_CUBE:
            begin
                mul_a = {18'd0, prod_reg[43:30]};
                mul_b = {10'd0, s_reg};
            end
            ST_SQ_E:
            begin
                mul_a = {1'b0, e_reg};
                mul_b = {1'b0, e_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next  = mul_a * mul_b;
    assign t_arg      = {prod_reg[31:0], 24'd0} + {16'd0, tlo_reg};
    assign s3         = prod_reg[35:30];
    assign s3_scaled  = {6'd0, s3};
    assign e_poly     = Q30_ONE - {9'd0, s_reg} + {18'd0, s2_reg[13:1]} - div6(s3_scaled[5:0]);
    assign e_rounded  = prod_reg[61:0] + Q30_HALF;
    assign kernel_sum = e_reg + KERNEL_HALF;
    assign out_load   = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    assign q_pop            = (state_reg == ST_IDLE) && !q_status.empty;
    assign out_valid        = out_valid_reg;
    assign kernel_value     = kernel_reg;
    assign distance_squared = dist_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        dist_reg  <= q_data;
                        state_reg <= ST_MUL_LO;
                    end
                end
                ST_MUL_LO:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI:
                begin
                    tlo_reg   <= prod_reg[39:0];
                    prod_reg  <= prod_next;
                    state_reg <= ST_ARG;
                end
                ST_ARG:
                begin
                    // an argument of 16 or more flushes the kernel to zero
                    if (t_arg[55:44] != 12'd0)
                    begin
                        e_reg     <= '0;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        s_reg     <= t_arg[43:22];
                        state_reg <= ST_SQ_S;
                    end
                end
                ST_SQ_S:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_CUBE;
                end
                ST_CUBE:
                begin
                    s2_reg    <= prod_reg[43:30];
                    prod_reg  <= prod_next;
                    state_reg <= ST_POLY;
                end
                ST_POLY:
                begin
                    e_reg      <= e_poly;
                    sq_cnt_reg <= '0;
                    state_reg  <= ST_SQ_E;
                end
                ST_SQ_E:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    e_reg      <= e_rounded[60:30];
                    sq_cnt_reg <= sq_cnt_reg + 4'd1;
                    state_reg  <= (sq_cnt_reg == 4'(SQUARINGS - 1)) ? ST_FIN : ST_SQ_E;
                end
                ST_FIN:
                begin
                    if (out_load)
                    begin
                        kernel_reg   <= kernel_sum[30:14];
                        dist_out_reg <= dist_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_kernel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (kernel_reg <= KERNEL_ONE))
        else $error("kernel value above one");

    a_square_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (sq_cnt_reg < 4'(SQUARINGS)))
        else $error("squaring count overran");

    a_e_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ_E) |-> (e_reg <= Q30_ONE))
        else $error("series value above one");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == ST_MUL_LO))
        else $error("pop did not start the sequencer");

endmodule

### dv/gaussian_kernel_entry_unit_tb.sv
module gaussian_kernel_entry_unit_tb
    import gke_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FEATURE_LIMIT = FEATURE_LIMIT_DEFAULT;
    // idle cycles after the last expected result; covers the kernel pipeline
    localparam int SETTLE_CYCLES = 48;
    localparam int DRAIN_LIMIT = 20000;
    localparam int PHASE_ITEMS = 58;
    localparam int PHASES = 8;
    localparam int TIMEOUT_NS = 2_000_000;
    localparam int REPORT_LIMIT = 10;
    // index one decodes to no register: a write there must leave everything alone
    localparam logic REG_UNMAPPED = 1'b1;
    localparam bit [63:0] Q30_ONE = 64'd1 << 30;
    localparam bit [63:0] Q30_HALF = 64'd1 << 29;
    localparam bit [63:0] EXP_ARG_LIMIT = 64'd16 << 40;
    localparam int SQUARINGS = 12;
    localparam bit [KERNEL_W-1:0] KERNEL_ONE = 17'd65536;

    typedef enum {ROW_CLEAN, ROW_OVERLONG, ROW_NOISY} row_kind_t;

    typedef struct packed {
        bit [KERNEL_W-1:0] kernel;
        bit [DIST_W-1:0]   distance;
    } kernel_entry_t;

    // Scoreboard: tracks the running distance of the open row and queues one
    // kernel entry per closed row, then matches the block's results in order.
    class kernel_entry_board_t;
        bit [BW_W-1:0]   inv_bw;
        bit [DIST_W-1:0] dist_acc;
        int              row_len;
        int              feature_limit;
        kernel_entry_t   entry_q[$];
        int              errors;
        int              rows;
        int              long_rows;
        int              zero_kernels;
        int              unit_kernels;
        int              results_seen;

        function new(int limit);
            feature_limit = limit;
            inv_bw = INV_BW_RESET;
            dist_acc = '0;
            row_len = 0;
            errors = 0;
            rows = 0;
            long_rows = 0;
            zero_kernels = 0;
            unit_kernels = 0;
            results_seen = 0;
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function int pending();
            return entry_q.size();
        endfunction

        function void write_reg(logic idx, bit [CFG_DATA_W-1:0] value);
            if (idx == REG_INV_BANDWIDTH)
                inv_bw = value[BW_W-1:0];
        endfunction

        // exp(-t) via a cubic series on t/4096, squared back up twelve times
        function bit [KERNEL_W-1:0] kernel_of(bit [DIST_W-1:0] distance);
            bit [63:0] t;
            bit [63:0] s;
            bit [63:0] s2;
            bit [63:0] s3;
            bit [63:0] e;
            t = 64'(distance) * 64'(inv_bw);
            if (t >= EXP_ARG_LIMIT)
                return '0;
            s = t >> 22;
            s2 = (s * s) >> 30;
            s3 = (s2 * s) >> 30;
            e = Q30_ONE - s + (s2 >> 1) - s3 / 64'd6;
            for (int i = 0; i < SQUARINGS; i++)
                e = (e * e + Q30_HALF) >> 30;
            e = (e + 64'd8192) >> 14;
            return e[KERNEL_W-1:0];
        endfunction

        function void take_feature(logic signed [SAMPLE_W-1:0] nv,
                                   logic signed [SAMPLE_W-1:0] bv, logic lf);
            int            diff;
            bit [63:0]     mag;
            bit [63:0]     sum;
            bit            closes;
            kernel_entry_t entry;
            diff = int'(nv) - int'(bv);
            if (diff < 0)
                diff = -diff;
            mag = 64'(diff);
            sum = 64'(dist_acc) + mag * mag;
            if (sum > 64'(ACC_MAX))
                sum = 64'(ACC_MAX);
            closes = lf;
            if (row_len + 1 >= feature_limit)
            begin
                if (!lf)
                    long_rows++;
                closes = 1'b1;
            end
            if (!closes)
            begin
                dist_acc = sum[DIST_W-1:0];
                row_len++;
                return;
            end
            entry.distance = sum[DIST_W-1:0];
            entry.kernel = kernel_of(entry.distance);
            if (entry.kernel == '0)
                zero_kernels++;
            if (entry.kernel == KERNEL_ONE)
                unit_kernels++;
            entry_q.push_back(entry);
            dist_acc = '0;
            row_len = 0;
            rows++;
        endfunction

        function void check_entry(bit [KERNEL_W-1:0] kernel, bit [DIST_W-1:0] distance);
            kernel_entry_t want;
            results_seen++;
            if (entry_q.size() == 0)
            begin
                fail($sformatf("result %0d arrived with nothing expected (kernel %0d, %0d)",
                               results_seen, kernel, distance));
                return;
            end
            want = entry_q.pop_front();
            if (kernel !== want.kernel)
                fail($sformatf("result %0d kernel_value expected %0d got %0d",
                               results_seen, want.kernel, kernel));
            if (distance !== want.distance)
                fail($sformatf("result %0d distance_squared expected %0d got %0d",
                               results_seen, want.distance, distance));
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] new_value;
    logic signed [SAMPLE_W-1:0] basis_value;
    logic                       last_feature;
    logic                       out_valid;
    logic                       out_stall;
    logic [KERNEL_W-1:0]        kernel_value;
    logic [DIST_W-1:0]          distance_squared;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [CFG_ADDR_W-1:0]      paddr;
    logic [CFG_DATA_W-1:0]      pwdata;
    logic [CFG_DATA_W-1:0]      prdata;
    logic                       pready;

    kernel_entry_board_t board;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int features_sent = 0;
    int bandwidth_writes = 0;

    gaussian_kernel_entry_unit #(
        .FEATURE_LIMIT (FEATURE_LIMIT)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .new_value        (new_value),
        .basis_value      (basis_value),
        .last_feature     (last_feature),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kernel_value     (kernel_value),
        .distance_squared (distance_squared),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 4 ns period
    always #2 clk = ~clk;

    // Receiver: stall the result channel at the rate set for the current phase.
    always @(posedge clk)
    begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);
    end

    // Monitor: every signal here was last written by a nonblocking assignment, so
    // reading at the edge sees the values that decided the handshake. Note the
    // input transaction first so a same-edge result always finds its entry.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.take_feature(new_value, basis_value, last_feature);
            if (out_valid && !out_stall)
                board.check_entry(kernel_value, distance_squared);
        end
    end

    // Drive one feature transaction. Idle the channel first at the phase's rate,
    // then hold valid and payload until the block takes it. Valid is left high on
    // return so back-to-back transactions never dip within one time step.
    task automatic send_feature(input logic signed [SAMPLE_W-1:0] a,
                                input logic signed [SAMPLE_W-1:0] b, input logic lf);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        new_value    <= a;
        basis_value  <= b;
        last_feature <= lf;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        features_sent++;
    endtask

    // Drop valid and wait for every queued entry, then let the pipeline settle.
    task automatic drain(input int max_cycles);
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (board.pending() > 0 && waited < max_cycles)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register over APB (setup + access), then read inv_bandwidth back
    // and compare it with the predicted register. Upper data bits are random junk.
    task automatic program_register(input logic idx, input bit [BW_W-1:0] value);
        bit [CFG_DATA_W-1:0]   word;
        logic [CFG_DATA_W-1:0] readback;
        word = $urandom();
        word[BW_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // the register takes the value at this edge
        board.write_reg(idx, word);
        if (idx == REG_INV_BANDWIDTH)
            bandwidth_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_INV_BANDWIDTH, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        // sample mid access phase, well away from any edge
        @(negedge clk);
        readback = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[BW_W-1:0] !== board.inv_bw)
            board.fail($sformatf("inv_bandwidth read back %0d, expected %0d",
                                 readback[BW_W-1:0], board.inv_bw));
    endtask

    function automatic logic signed [SAMPLE_W-1:0] corner_value();
        unique case ($urandom_range(4, 0))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    // Send one row pair. Clean rows flag only their final feature. Overlong rows
    // run to the feature limit unflagged so the block must close them on its own;
    // any features past the limit form a fresh row that gets a flag at the end.
    // Noisy rows scatter last flags at random and still close with one.
    task automatic send_row(input int len, input row_kind_t kind);
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        logic                       lf;
        int                         sel;
        int                         delta;
        for (int i = 0; i < len; i++)
        begin
            sel = $urandom_range(9, 0);
            a = SAMPLE_W'($urandom());
            b = SAMPLE_W'($urandom());
            if (sel == 0)
            begin
                a = corner_value();
                b = corner_value();
            end
            else if (sel >= 5)
            begin
                // near neighbors keep the kernel away from zero
                delta = $urandom_range(1 << $urandom_range(15, 0), 0);
                b = sel[0] ? SAMPLE_W'(a + delta) : SAMPLE_W'(a - delta);
            end
            unique case (kind)
                ROW_CLEAN:    lf = (i == len - 1);
                ROW_OVERLONG: lf = (i == len - 1) && (len > FEATURE_LIMIT);
                default:      lf = (i == len - 1) || ($urandom_range(4, 0) == 0);
            endcase
            send_feature(a, b, lf);
        end
    endtask

    // Watchdog: fail the run if it hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("watchdog expired with %0d entries outstanding", board.pending());
        $display("** gaussian_kernel_entry_unit: FAILED **");
        $finish;
    end

    initial
    begin
        int         items;
        int         kind;
        int         len;
        bit         paused;
        bit [BW_W-1:0] bw;

        board = new(FEATURE_LIMIT);
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        new_value    <= '0;
        basis_value  <= '0;
        last_feature <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset bandwidth, no idling.
        // Equal features: distance zero, kernel exactly one.
        send_feature(16'sh0000, 16'sh0000, 1'b1);
        // Largest difference in both directions, and equal extremes.
        send_feature(16'sh7FFF, 16'sh8000, 1'b1);
        send_feature(16'sh8000, 16'sh7FFF, 1'b1);
        send_feature(16'sh8000, 16'sh8000, 1'b1);
        // Alternating bit patterns in a two-feature row.
        send_feature(16'sh5555, 16'shAAAA, 1'b0);
        send_feature(16'shAAAA, 16'sh5555, 1'b1);
        // Smallest nonzero difference.
        send_feature(16'sh0001, 16'sh0000, 1'b1);
        // Four maximal differences push the exponent past its limit: kernel flushes.
        repeat (3) send_feature(16'sh7FFF, 16'sh8000, 1'b0);
        send_feature(16'sh7FFF, 16'sh8000, 1'b1);
        drain(DRAIN_LIMIT);

        // Write to an unmapped index: inv_bandwidth must keep its reset value.
        program_register(REG_UNMAPPED, 16'($urandom()));
        // Zero bandwidth: exponent is zero whatever the distance.
        program_register(REG_INV_BANDWIDTH, 16'd0);
        send_feature(16'sh7FFF, 16'sh8000, 1'b1);
        drain(DRAIN_LIMIT);
        // Widest kernel argument.
        program_register(REG_INV_BANDWIDTH, 16'hFFFF);
        send_feature(16'sh0100, 16'sh0000, 1'b1);
        send_feature(16'sh7FFF, 16'sh8000, 1'b1);
        drain(DRAIN_LIMIT);

        // Random part: one bandwidth and one idling mode per phase. Phases end on a
        // row boundary and drain before the next register write.
        for (int p = 0; p < PHASES; p++)
        begin
            unique case (p)
                0: bw = INV_BW_RESET;
                1: bw = 16'd1;
                2: bw = 16'hFFFF;
                3: bw = 16'd0;
                5: bw = 16'd200;
                7: bw = 16'd40000;
                default: bw = $urandom_range(65535, 1);
            endcase
            program_register(REG_INV_BANDWIDTH, bw);
            unique case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 84;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 84;
                end
                default:
                begin
                    send_idle_pct = 22;
                    stall_pct = 22;
                end
            endcase
            items = 0;
            paused = 1'b0;
            while (items < PHASE_ITEMS)
            begin
                kind = $urandom_range(99, 0);
                if (kind < 60)
                begin
                    len = $urandom_range(6, 1);
                    send_row(len, ROW_CLEAN);
                end
                else if (kind < 85)
                begin
                    len = $urandom_range(24, 7);
                    send_row(len, ROW_CLEAN);
                end
                else if (kind < 93)
                begin
                    len = $urandom_range(FEATURE_LIMIT, 25);
                    send_row(len, ROW_CLEAN);
                end
                else if (kind < 97)
                begin
                    len = FEATURE_LIMIT + $urandom_range(8, 0);
                    send_row(len, ROW_OVERLONG);
                end
                else
                begin
                    len = $urandom_range(10, 1);
                    send_row(len, ROW_NOISY);
                end
                items += len;
                // Hold the sender once mid-phase until every result is back.
                if (p == 5 && !paused && items >= PHASE_ITEMS / 2)
                begin
                    drain(DRAIN_LIMIT);
                    paused = 1'b1;
                end
            end
            drain(DRAIN_LIMIT);
        end

        send_idle_pct = 0;
        stall_pct = 0;
        drain(DRAIN_LIMIT);
        if (board.pending() != 0)
            board.fail($sformatf("%0d kernel entries never arrived", board.pending()));

        $display("Covered %0d features in %0d rows (%0d closed at the feature limit), %0d %s",
                 features_sent, board.rows, board.long_rows, bandwidth_writes,
                 "bandwidth writes, all idling mixes.");
        $display("Kernel flushed to zero %0d times, equal to one %0d times; %0d mismatches.",
                 board.zero_kernels, board.unit_kernels, board.errors);
        if (board.errors == 0)
            $display("** gaussian_kernel_entry_unit: PASSED **");
        else
            $display("** gaussian_kernel_entry_unit: FAILED **");
        $finish;
    end

endmodule
